[hdl/ledpbr_pkg.sv]
// Package for the LED panel refresh engine: sizes, operation and kind codes,
// digit code layout and the indicator-to-row tables.
// No dependencies.
package ledpbr_pkg;

	localparam int NUM_DIGITS    = 12;
	localparam int PATTERN_STEPS = 8;
	localparam int NUM_IND       = 12;
	localparam int NUM_FLASH     = 6;

	localparam int DIG_AW  = $clog2(NUM_DIGITS);
	localparam int IND_AW  = $clog2(NUM_IND);
	localparam int FL_AW   = $clog2(NUM_FLASH);
	localparam int PSTEP_W = $clog2(PATTERN_STEPS);
	localparam int OUT_CW  = $clog2(NUM_DIGITS + 3);

	localparam logic [3:0] PHASE_LAST     = 4'd9;
	localparam logic [2:0] STEP_LAST_TICK = 3'd5;
	localparam logic [PSTEP_W-1:0] PSTEP_LAST = PSTEP_W'(PATTERN_STEPS - 1);

	localparam logic [3:0] DIGIT_BLANK = 4'd15;
	localparam logic [3:0] DIGIT_OFF   = 4'd10;
	localparam logic [3:0] DIGIT_RAW_A = 4'd11;
	localparam logic [3:0] DIGIT_RAW_B = 4'd12;
	localparam logic [3:0] DIGIT_RAW_C = 4'd13;
	localparam logic [3:0] DIGIT_NONE  = 4'd14;
	localparam logic [3:0] DIGIT_MAX_HEX = 4'd9;

	localparam logic [7:0] RAW_A_BITS = 8'h40;
	localparam logic [7:0] RAW_B_BITS = 8'h01;
	localparam logic [7:0] RAW_C_BITS = 8'h41;

	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_DIGIT = 3'd1;
	localparam logic [2:0] OP_DOT   = 3'd2;
	localparam logic [2:0] OP_BLINK = 3'd3;
	localparam logic [2:0] OP_PAT   = 3'd4;
	localparam logic [2:0] OP_FLASH = 3'd5;

	localparam logic [1:0] KIND_RAW    = 2'd0;
	localparam logic [1:0] KIND_HEX    = 2'd1;
	localparam logic [1:0] KIND_BLANK  = 2'd2;
	localparam logic [1:0] KIND_BRIGHT = 2'd3;

	// Flash numbers.
	localparam logic [FL_AW-1:0] FL_PLUS  = FL_AW'(0);
	localparam logic [FL_AW-1:0] FL_MINUS = FL_AW'(1);
	localparam logic [FL_AW-1:0] FL_SLEEP = FL_AW'(2);
	localparam logic [FL_AW-1:0] FL_IR    = FL_AW'(3);
	localparam logic [FL_AW-1:0] FL_POWER = FL_AW'(4);
	localparam logic [FL_AW-1:0] FL_CLOCK = FL_AW'(5);

	localparam logic [3:0] IND_IR_RX = 4'd11;
	localparam logic [1:0] FLASH_LOAD = 2'd2;

	typedef struct packed {
		logic       blink;
		logic       dot;
		logic [3:0] val;
	} dcode_t;

	localparam dcode_t DCODE_RESET = '{blink: 1'b0, dot: 1'b0, val: DIGIT_BLANK};

	// Row select for an indicator: 0 selects row a, 1 row b.
	function automatic logic ind_row(input logic [3:0] k);
		case (k)
			4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10: ind_row = 1'b1;
			default: ind_row = 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] ind_mask(input logic [3:0] k);
		case (k)
			4'd0:    ind_mask = 8'h0A;
			4'd1:    ind_mask = 8'h40;
			4'd2:    ind_mask = 8'h04;
			4'd3:    ind_mask = 8'h04;
			4'd4:    ind_mask = 8'h08;
			4'd5:    ind_mask = 8'h80;
			4'd6:    ind_mask = 8'h10;
			4'd7:    ind_mask = 8'h01;
			4'd8:    ind_mask = 8'h20;
			4'd9:    ind_mask = 8'h02;
			4'd10:   ind_mask = 8'h40;
			4'd11:   ind_mask = 8'h20;
			default: ind_mask = 8'h00;
		endcase
	endfunction

endpackage

[hdl/led_panel_blink_refresh.sv]
// Refresh engine for a two-chip LED matrix driver: digit store and pattern store
// in synchronous memories, flash counters, phase and step timers, command sequencer.
// Depends on ledpbr_pkg.
//
//   channel  | signals                                   | handshake
//   ---------+-------------------------------------------+-------------------------------
//   command  | operation, index, value                   | taken when start & !busy
//   result   | device, row, kind, payload, dot, last     | strobe high one cycle, no stall
//   config   | cfg_we, cfg_data (case brightness)        | written on any edge with cfg_we
//
// Digit, dot and blink setup read the digit memory, then write it back in ST_WR;
// other setup words complete on acceptance. A tick runs the command burst, preceded
// on a pattern step by a walk of the pattern memory, one entry a cycle.
// Each result passes the output register, so results trail busy by that register.
// Reset is asynchronous; valid bits make unwritten entries read as their reset
// value, so no clearing pass is needed. The receiver cannot stall.
module led_panel_blink_refresh (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] operation,
	input  logic [3:0] index,
	input  logic [7:0] value,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	output logic       strobe,
	output logic       device,
	output logic [2:0] row,
	output logic [1:0] kind,
	output logic [7:0] payload,
	output logic       dot,
	output logic       last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WR   = 2'd1;
	localparam logic [1:0] ST_PAT  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [3:0] phase_cnt_q;
	logic       phase_q;
	logic [2:0] step_cnt_q;
	logic [ledpbr_pkg::PSTEP_W-1:0] pstep_q;
	logic [7:0] row_a_q;
	logic [7:0] row_b_q;
	logic [1:0] flash_q [ledpbr_pkg::NUM_FLASH];
	logic [ledpbr_pkg::NUM_DIGITS-1:0] dig_vld_q;
	logic [ledpbr_pkg::NUM_IND-1:0]    pat_vld_q;
	logic       pat11_zero_q;
	logic [ledpbr_pkg::OUT_CW-1:0] cnt_q;
	logic [7:0] bright_q;
	logic       strobe_q;

	logic [2:0] op_q;
	logic [3:0] idx_q;
	logic [7:0] val_q;

	ledpbr_pkg::dcode_t dig_mem [ledpbr_pkg::NUM_DIGITS];
	logic [7:0]         pat_mem [ledpbr_pkg::NUM_IND];
	ledpbr_pkg::dcode_t dig_rd_q;
	logic               dig_rdv_q;
	logic [7:0]         pat_rd_q;
	logic               pat_rdv_q;

	logic       accept;
	logic [3:0] dig_raddr;
	logic [3:0] pat_raddr;
	ledpbr_pkg::dcode_t dig_eff;
	ledpbr_pkg::dcode_t dig_wdata;
	logic [7:0] pat_eff;

	logic [3:0] ph_nxt;
	logic       tog_nxt;
	logic [2:0] stc_nxt;
	logic       step_go;
	logic [ledpbr_pkg::PSTEP_W-1:0] ps_nxt;
	logic [7:0] ra_fl;
	logic [7:0] rb_fl;

	logic [3:0] pk;
	logic [7:0] pmask;
	logic       pbit;

	logic [3:0] de;
	logic       o_stb;
	logic       o_dev;
	logic [2:0] o_row;
	logic [1:0] o_kind;
	logic [7:0] o_pay;
	logic       o_dot;
	logic       o_last;

	logic       dev_out_q;
	logic [2:0] row_out_q;
	logic [1:0] kind_out_q;
	logic [7:0] pay_out_q;
	logic       dot_out_q;
	logic       last_out_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign strobe  = strobe_q;
	assign device  = dev_out_q;
	assign row     = row_out_q;
	assign kind    = kind_out_q;
	assign payload = pay_out_q;
	assign dot     = dot_out_q;
	assign last    = last_out_q;

	// Tick bookkeeping: timers and flash rows, taken as one step on acceptance.
	always_comb begin
		if (phase_cnt_q == ledpbr_pkg::PHASE_LAST) begin
			ph_nxt  = 4'd0;
			tog_nxt = !phase_q;
		end else begin
			ph_nxt  = phase_cnt_q + 4'd1;
			tog_nxt = phase_q;
		end
		stc_nxt = step_cnt_q + 3'd1;
		step_go = (stc_nxt > ledpbr_pkg::STEP_LAST_TICK);
		if (pstep_q == '0) begin
			ps_nxt = ledpbr_pkg::PSTEP_LAST;
		end else begin
			ps_nxt = pstep_q - ledpbr_pkg::PSTEP_W'(1);
		end

		ra_fl = row_a_q;
		rb_fl = row_b_q;
		// Plus and minus clear when idle; power, sleep and clock hold their bit.
		if (flash_q[ledpbr_pkg::FL_PLUS] != 2'd0) rb_fl[4] = 1'b1;
		else rb_fl[4] = 1'b0;
		if (flash_q[ledpbr_pkg::FL_MINUS] != 2'd0) rb_fl[7] = 1'b1;
		else rb_fl[7] = 1'b0;
		if (flash_q[ledpbr_pkg::FL_POWER] != 2'd0) ra_fl[6] = 1'b1;
		if (flash_q[ledpbr_pkg::FL_SLEEP] != 2'd0) ra_fl[2] = 1'b1;
		if (flash_q[ledpbr_pkg::FL_CLOCK] != 2'd0) rb_fl[2] = 1'b1;
		// The ir bit stays when the ir receive pattern is running.
		if (flash_q[ledpbr_pkg::FL_IR] != 2'd0) rb_fl[3] = 1'b1;
		else if (pat11_zero_q) rb_fl[3] = 1'b0;
	end

	// Memory read addresses and the effective (valid-qualified) read data.
	always_comb begin
		if (state_q == ST_IDLE) begin
			dig_raddr = index;
		end else begin
			dig_raddr = 4'(cnt_q) - 4'd1;
		end
		pat_raddr = 4'(cnt_q);
		dig_eff   = dig_rdv_q ? dig_rd_q : ledpbr_pkg::DCODE_RESET;
		pat_eff   = pat_rdv_q ? pat_rd_q : 8'h00;

		dig_wdata = dig_eff;
		case (op_q)
			ledpbr_pkg::OP_DIGIT: begin
				dig_wdata.val = (val_q > 8'(ledpbr_pkg::DIGIT_BLANK)) ?
					ledpbr_pkg::DIGIT_BLANK : val_q[3:0];
			end
			ledpbr_pkg::OP_DOT:   dig_wdata.dot   = val_q[0];
			ledpbr_pkg::OP_BLINK: dig_wdata.blink = val_q[0];
			default: dig_wdata = dig_eff;
		endcase

		pk    = 4'(cnt_q) - 4'd1;
		pmask = ledpbr_pkg::ind_mask(pk);
		pbit  = pat_eff[pstep_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WR) begin
			dig_mem[idx_q[ledpbr_pkg::DIG_AW-1:0]] <= dig_wdata;
		end
		dig_rd_q <= dig_mem[dig_raddr[ledpbr_pkg::DIG_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (accept && operation == ledpbr_pkg::OP_PAT &&
				index < 4'(ledpbr_pkg::NUM_IND)) begin
			pat_mem[index[ledpbr_pkg::IND_AW-1:0]] <= value;
		end
		pat_rd_q <= pat_mem[pat_raddr[ledpbr_pkg::IND_AW-1:0]];
	end

	// Result formation in the command burst.
	always_comb begin
		de     = 4'(cnt_q) - 4'd2;
		o_stb  = 1'b0;
		o_dev  = 1'b0;
		o_row  = 3'd0;
		o_kind = ledpbr_pkg::KIND_RAW;
		o_pay  = 8'h00;
		o_dot  = 1'b0;
		o_last = 1'b0;
		if (state_q == ST_OUT) begin
			o_stb = 1'b1;
			if (cnt_q == '0) begin
				o_dev = 1'b1;
				o_pay = row_a_q;
			end else if (cnt_q == ledpbr_pkg::OUT_CW'(1)) begin
				o_dev = 1'b1;
				o_row = 3'd3;
				o_pay = row_b_q;
			end else if (cnt_q == ledpbr_pkg::OUT_CW'(ledpbr_pkg::NUM_DIGITS + 2)) begin
				o_kind = ledpbr_pkg::KIND_BRIGHT;
				o_pay  = bright_q;
				o_last = 1'b1;
			end else begin
				o_dev = (de >= 4'd8);
				o_row = (de < 4'd8) ? 3'(4'd7 - de) : 3'(4'd15 - de);
				o_dot = dig_eff.dot;
				if (dig_eff.val == ledpbr_pkg::DIGIT_BLANK || (dig_eff.blink && phase_q)) begin
					o_kind = ledpbr_pkg::KIND_BLANK;
				end else if (de == 4'd0 && dig_eff.val > ledpbr_pkg::DIGIT_MAX_HEX) begin
					// Digit 0 carries the special codes: blank, three raw rows, nothing.
					o_row = 3'd7;
					o_dev = 1'b0;
					case (dig_eff.val)
						ledpbr_pkg::DIGIT_OFF: o_kind = ledpbr_pkg::KIND_BLANK;
						ledpbr_pkg::DIGIT_RAW_A: begin
							o_pay = ledpbr_pkg::RAW_A_BITS;
							o_dot = 1'b0;
						end
						ledpbr_pkg::DIGIT_RAW_B: begin
							o_pay = ledpbr_pkg::RAW_B_BITS;
							o_dot = 1'b0;
						end
						ledpbr_pkg::DIGIT_RAW_C: begin
							o_pay = ledpbr_pkg::RAW_C_BITS;
							o_dot = 1'b0;
						end
						default: o_stb = 1'b0;
					endcase
				end else begin
					o_kind = ledpbr_pkg::KIND_HEX;
					o_pay  = {4'd0, dig_eff.val};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		dev_out_q  <= o_dev;
		row_out_q  <= o_row;
		kind_out_q <= o_kind;
		pay_out_q  <= o_pay;
		dot_out_q  <= o_dot;
		last_out_q <= o_last;
		if (accept) begin
			op_q  <= operation;
			idx_q <= index;
			val_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_cnt_q  <= 4'd0;
			phase_q      <= 1'b0;
			step_cnt_q   <= 3'd0;
			pstep_q      <= ledpbr_pkg::PSTEP_LAST;
			row_a_q      <= 8'h00;
			row_b_q      <= 8'h00;
			for (int i = 0; i < ledpbr_pkg::NUM_FLASH; i++) flash_q[i] <= 2'd0;
			dig_vld_q    <= '0;
			pat_vld_q    <= '0;
			pat11_zero_q <= 1'b1;
			cnt_q        <= '0;
			bright_q     <= 8'd1;
			strobe_q     <= 1'b0;
			dig_rdv_q    <= 1'b0;
			pat_rdv_q    <= 1'b0;
		end else begin
			strobe_q  <= o_stb;
			dig_rdv_q <= (dig_raddr < 4'(ledpbr_pkg::NUM_DIGITS)) &&
				dig_vld_q[dig_raddr[ledpbr_pkg::DIG_AW-1:0]];
			pat_rdv_q <= (pat_raddr < 4'(ledpbr_pkg::NUM_IND)) &&
				pat_vld_q[pat_raddr[ledpbr_pkg::IND_AW-1:0]];
			if (cfg_we) begin
				bright_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (operation)
							ledpbr_pkg::OP_TICK: begin
								phase_cnt_q <= ph_nxt;
								phase_q     <= tog_nxt;
								row_a_q     <= ra_fl;
								row_b_q     <= rb_fl;
								for (int i = 0; i < ledpbr_pkg::NUM_FLASH; i++) begin
									if (flash_q[i] != 2'd0) flash_q[i] <= flash_q[i] - 2'd1;
								end
								cnt_q <= '0;
								if (step_go) begin
									step_cnt_q <= 3'd0;
									pstep_q    <= ps_nxt;
									state_q    <= ST_PAT;
								end else begin
									step_cnt_q <= stc_nxt;
									state_q    <= ST_OUT;
								end
							end
							ledpbr_pkg::OP_DIGIT, ledpbr_pkg::OP_DOT,
							ledpbr_pkg::OP_BLINK: begin
								if (index < 4'(ledpbr_pkg::NUM_DIGITS)) state_q <= ST_WR;
							end
							ledpbr_pkg::OP_PAT: begin
								if (index < 4'(ledpbr_pkg::NUM_IND)) begin
									pat_vld_q[index[ledpbr_pkg::IND_AW-1:0]] <= 1'b1;
								end
								if (index == ledpbr_pkg::IND_IR_RX) begin
									pat11_zero_q <= (value == 8'h00);
								end
							end
							ledpbr_pkg::OP_FLASH: begin
								if (index < 4'(ledpbr_pkg::NUM_FLASH)) begin
									flash_q[index[ledpbr_pkg::FL_AW-1:0]] <= ledpbr_pkg::FLASH_LOAD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_WR: begin
					dig_vld_q[idx_q[ledpbr_pkg::DIG_AW-1:0]] <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_PAT: begin
					// Entry cnt-1 arrives from the pattern memory while entry cnt is read.
					if (cnt_q != '0) begin
						if (ledpbr_pkg::ind_row(pk)) begin
							row_b_q <= pbit ? (row_b_q | pmask) : (row_b_q & ~pmask);
						end else begin
							row_a_q <= pbit ? (row_a_q | pmask) : (row_a_q & ~pmask);
						end
					end
					if (cnt_q == ledpbr_pkg::OUT_CW'(ledpbr_pkg::NUM_IND)) begin
						cnt_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q + ledpbr_pkg::OUT_CW'(1);
					end
				end
				ST_OUT: begin
					if (cnt_q == ledpbr_pkg::OUT_CW'(ledpbr_pkg::NUM_DIGITS + 2)) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + ledpbr_pkg::OUT_CW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
